@@ src/asl_pkg.sv @@
// Shared types and constants for the audio soft limiter.
`timescale 1ns / 1ps
`default_nettype none
package asl_pkg;
    localparam int SAMPLE_W = 24;
    localparam int OUT_W    = 22;
    localparam int MAG_W    = 24;
    localparam int RES_W    = 21;
    localparam int NBITS    = 21;
    // Search remainder and running product widths, both two's complement.
    localparam int D_W      = 96;
    localparam int W_W      = 72;

    typedef enum logic [1:0] {
        MODE_ISQRT = 2'd0,
        MODE_CUBIC = 2'd1,
        MODE_HARD  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    localparam logic [MAG_W-1:0] Q_ONE     = 24'd1048576;
    localparam logic [MAG_W-1:0] CUBIC_LIM = 24'd1572864;
    // Bias that turns the cube quotient into round to nearest, ties toward zero.
    localparam logic [62:0]      CUBIC_RND = 63'((64'd27 << 37) - 64'd1);
    // ceil(2^32 / 27): exact floor division by 27 for any 24-bit dividend.
    localparam logic [27:0]      DIV27_RECIP = 28'd159072863;
    localparam logic [48:0]      S_BIAS    = 49'(64'd1 << 40);

    // Control and data that travel down the pipeline with each item.
    typedef struct packed {
        logic              valid;
        logic              neg;
        t_mode             mode;
        logic [MAG_W-1:0]  mag;
    } t_front;
endpackage
`default_nettype wire

@@ src/audio_soft_limiter_core.sv @@
// Top level of the audio soft limiter pipeline.
// One sample per cycle while not stalled: five front stages (magnitude,
// squares, partial cube products, cube sum with search start values, divide
// by 27), 21 stages of a bit-per-stage inverse square root search, one output
// stage. A stall freezes the whole pipeline; limit_mode is sampled as each
// item enters and should only be written while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none
module audio_soft_limiter_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [23:0] i_sample_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [21:0] o_sample_out,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_limit_mode
);
    import asl_pkg::*;

    logic [1:0]     r_limit_mode;
    logic           adv;
    t_front         ctl [0:NBITS];
    logic [48:0]    s   [0:NBITS];
    logic [D_W-1:0] d   [0:NBITS];
    logic [W_W-1:0] w   [0:NBITS];
    logic [20:0]    m   [0:NBITS];
    logic [19:0]    cub [0:NBITS];
    logic           r_valid;
    logic [21:0]    r_out;
    logic [23:0]    mag;
    logic [20:0]    res;

    assign o_cfg_ready = 1'b1;

    // Hold the mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_mode <= 2'd0;
        end else if (i_cfg_valid) begin
            r_limit_mode <= i_cfg_limit_mode;
        end
    end

    // Advance when output is free.
    assign adv     = !(r_valid && i_stall);
    assign o_stall = !adv;

    asl_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv), .i_valid(i_valid),
        .i_mode(r_limit_mode), .i_sample(i_sample_in),
        .o_ctl(ctl[0]), .o_s(s[0]), .o_d(d[0]), .o_w(w[0]), .o_cub(cub[0])
    );
    assign m[0] = 21'd0;

    genvar g;
    generate
        for (g = 0; g < NBITS; g++) begin : g_bit
            asl_isqrt_stage #(.BIT(NBITS - 1 - g)) u_bit (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv),
                .i_ctl(ctl[g]), .i_s(s[g]), .i_d(d[g]), .i_w(w[g]),
                .i_m(m[g]), .i_cub(cub[g]),
                .o_ctl(ctl[g+1]), .o_s(s[g+1]), .o_d(d[g+1]), .o_w(w[g+1]),
                .o_m(m[g+1]), .o_cub(cub[g+1])
            );
        end
    endgenerate

    // Pick the curve and restore the sign.
    always_comb begin
        mag = ctl[NBITS].mag;
        case (ctl[NBITS].mode)
            MODE_ISQRT: res = m[NBITS];
            MODE_CUBIC: res = ((mag > CUBIC_LIM) ? 21'(CUBIC_LIM) : mag[20:0])
                              - {1'b0, cub[NBITS]};
            MODE_HARD:  res = (mag > Q_ONE) ? 21'(Q_ONE) : mag[20:0];
            default:    res = 21'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= ctl[NBITS].valid;
            r_out   <= ctl[NBITS].neg ? (22'd0 - {1'b0, res}) : {1'b0, res};
        end
    end

    assign o_valid      = r_valid;
    assign o_sample_out = r_out;

`ifndef ASSERT_OFF
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sample_out <= 22'sd1048576 && o_sample_out >= -22'sd1048576))
        else $error("output out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("item lost under stall");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("spurious input stall");
`endif
endmodule
`default_nettype wire

@@ src/asl_isqrt_stage.sv @@
// One bit of the inverse square root search for the limiter.
`timescale 1ns / 1ps
`default_nettype none
module asl_isqrt_stage #(
    parameter int BIT = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    input  wire asl_pkg::t_front i_ctl,
    input  wire logic [48:0] i_s,
    input  wire logic [asl_pkg::D_W-1:0] i_d,
    input  wire logic [asl_pkg::W_W-1:0] i_w,
    input  wire logic [20:0] i_m,
    input  wire logic [19:0] i_cub,
    output asl_pkg::t_front  o_ctl,
    output logic [48:0]      o_s,
    output logic [asl_pkg::D_W-1:0] o_d,
    output logic [asl_pkg::W_W-1:0] o_w,
    output logic [20:0]      o_m,
    output logic [19:0]      o_cub
);
    import asl_pkg::*;

    logic [20:0]    k;
    logic [D_W-1:0] w_ext;
    logic [D_W-1:0] d_try;
    logic           take;
    t_front         r_ctl;
    logic [48:0]    r_s;
    logic [D_W-1:0] r_d;
    logic [W_W-1:0] r_w;
    logic [20:0]    r_m;
    logic [19:0]    r_cub;

    // Try setting this bit: keep it if k <= 2^20 and (2k-1)^2 * (a^2+2^40) <= 2^42 * a^2.
    // D holds 2^42*a^2 - (2m-1)^2*s and W holds (2m-1)*s, so the test is
    // two shifted subtracts and a sign check.
    always_comb begin
        k     = i_m | (21'd1 << BIT);
        w_ext = {{(D_W - W_W){i_w[W_W-1]}}, i_w};
        d_try = i_d - (w_ext << (BIT + 2)) - (D_W'(i_s) << (2 * BIT + 2));
        take  = ({3'd0, k} <= Q_ONE) && !d_try[D_W-1];
    end

    // Advance one bit per stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
            r_s   <= i_s;
            r_d   <= take ? d_try : i_d;
            r_w   <= take ? (i_w + (W_W'(i_s) << (BIT + 1))) : i_w;
            r_m   <= take ? k : i_m;
            r_cub <= i_cub;
        end
    end

    assign o_ctl = r_ctl;
    assign o_s   = r_s;
    assign o_d   = r_d;
    assign o_w   = r_w;
    assign o_m   = r_m;
    assign o_cub = r_cub;
endmodule
`default_nettype wire

@@ src/asl_front.sv @@
// Front stages: magnitude, squares, search start values and the cubic term.
`timescale 1ns / 1ps
`default_nettype none
module asl_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    input  wire logic        i_valid,
    input  wire logic [1:0]  i_mode,
    input  wire logic [23:0] i_sample,
    output asl_pkg::t_front  o_ctl,
    output logic [48:0]      o_s,
    output logic [asl_pkg::D_W-1:0] o_d,
    output logic [asl_pkg::W_W-1:0] o_w,
    output logic [19:0]      o_cub
);
    import asl_pkg::*;

    t_front         r_c1, r_c2, r_c3, r_c4, r_c5;
    logic [20:0]    r_ca1, r_ca2;
    logic [47:0]    r_sq2, r_sq3;
    logic [41:0]    r_cs2;
    logic [41:0]    r_ph3, r_pl3;
    logic [48:0]    r_s3, r_s4, r_s5;
    logic [D_W-1:0] r_d4, r_d5;
    logic [W_W-1:0] r_w4, r_w5;
    logic [23:0]    r_n4;
    logic [19:0]    r_q5;
    logic [23:0]    a;
    logic [62:0]    cube_rnd;
    logic [51:0]    quot;

    always_comb begin
        a        = i_sample[23] ? (24'd0 - i_sample) : i_sample;
        cube_rnd = {r_ph3, 21'd0} + 63'(r_pl3) + CUBIC_RND;
        quot     = 52'(r_n4) * 52'(DIV27_RECIP);
    end

    // Stage 1: magnitude; stage 2: squares; stage 3: partial cube products
    // and s; stage 4: cube sum and search start values; stage 5: divide by 27.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1.valid <= 1'b0;
            r_c2.valid <= 1'b0;
            r_c3.valid <= 1'b0;
            r_c4.valid <= 1'b0;
            r_c5.valid <= 1'b0;
        end else if (i_adv) begin
            r_c1.valid <= i_valid;
            r_c1.neg   <= i_sample[23];
            r_c1.mode  <= t_mode'(i_mode);
            r_c1.mag   <= a;
            r_ca1      <= (a > CUBIC_LIM) ? 21'(CUBIC_LIM) : a[20:0];
            r_c2       <= r_c1;
            r_sq2      <= r_c1.mag * r_c1.mag;
            r_cs2      <= r_ca1 * r_ca1;
            r_ca2      <= r_ca1;
            r_c3       <= r_c2;
            r_sq3      <= r_sq2;
            r_s3       <= {1'b0, r_sq2} + S_BIAS;
            r_ph3      <= r_cs2[41:21] * r_ca2;
            r_pl3      <= r_cs2[20:0] * r_ca2;
            r_c4       <= r_c3;
            r_s4       <= r_s3;
            r_d4       <= D_W'({r_sq3, 42'd0}) - D_W'(r_s3);
            r_w4       <= -(W_W'(r_s3));
            r_n4       <= cube_rnd[61:38];
            r_c5       <= r_c4;
            r_s5       <= r_s4;
            r_d5       <= r_d4;
            r_w5       <= r_w4;
            r_q5       <= quot[51:32];
        end
    end

    assign o_ctl = r_c5;
    assign o_s   = r_s5;
    assign o_d   = r_d5;
    assign o_w   = r_w5;
    assign o_cub = r_q5;
endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the audio soft limiter core.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import asl_pkg::*;

    localparam int LATENCY   = 27;
    localparam int MAX_CYCLES = 400000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [23:0]       i_sample_in = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic signed [21:0] o_sample_out;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_limit_mode = '0;

    audio_soft_limiter_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_sample_in(i_sample_in),
        .o_valid(o_valid), .i_stall(i_stall), .o_sample_out(o_sample_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_limit_mode(i_cfg_limit_mode)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_mode              cur_mode;
    logic signed [21:0] pending_samples[$];
    int                 err_count = 0;
    int                 cycle_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    bit                 hold_recv = 1'b0;

    // Round |x|/sqrt(x^2+1) in Q4.20 by a bitwise search on exact wide compares.
    function automatic logic [20:0] isqrt_curve(input logic [23:0] mag);
        logic [127:0] sq, sum, rhs, k, t;
        logic [20:0] res;
        res = '0;
        sq  = mag * mag;
        sum = sq + (128'd1 << 40);
        rhs = sq << 42;
        for (int b = 20; b >= 0; b--) begin
            k = res | (128'd1 << b);
            if (k <= 128'd1048576) begin
                t = 2 * k - 1;
                if (t * t * sum <= rhs) res = k[20:0];
            end
        end
        return res;
    endfunction

    // Cubic soft clip on the magnitude, quotient rounded with ties toward zero.
    function automatic logic [20:0] cubic_curve(input logic [23:0] mag);
        logic [95:0] a, div, q;
        a   = (mag > CUBIC_LIM) ? CUBIC_LIM : mag;
        div = 96'd27 << 38;
        q   = (a * a * a + div / 2 - 1) / div;
        return 21'(a - q);
    endfunction

    function automatic logic signed [21:0] limit_sample(input t_mode mode,
                                                        input logic [23:0] x);
        logic        neg;
        logic [23:0] mag;
        logic [21:0] m;
        neg = x[23];
        mag = neg ? 24'(-x) : x;
        case (mode)
            MODE_ISQRT: m = 22'(isqrt_curve(mag));
            MODE_CUBIC: m = 22'(cubic_curve(mag));
            MODE_HARD:  m = (mag > Q_ONE) ? 22'(Q_ONE) : mag[21:0];
            default:    m = '0;
        endcase
        return neg ? -m : m;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    task automatic write_mode(input t_mode mode);
        @(posedge i_clk);
        i_cfg_valid      <= 1'b1;
        i_cfg_limit_mode <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_mode = mode;
    endtask

    // Offer one item, waiting out sender gaps and stalls; expect the given value.
    task automatic send_sample(input logic [23:0] x, input logic signed [21:0] want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample_in <= x;
        do @(posedge i_clk); while (o_stall);
        pending_samples.push_back(want);
    endtask

    task automatic send_checked(input logic [23:0] x);
        send_sample(x, limit_sample(cur_mode, x));
    endtask

    // Drop valid at once so the last item is not offered again, then empty out.
    task automatic drain;
        i_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // Receiver side: random stall, with an optional long hold-off.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        i_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
        if (cycle_count > MAX_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_samples.size() == 0)
                report_mismatch("result with nothing expected");
            else begin
                logic signed [21:0] want;
                want = pending_samples.pop_front();
                if (o_sample_out !== want)
                    report_mismatch($sformatf("sample_out %0d, want %0d",
                                              o_sample_out, want));
            end
        end
    end

    typedef struct {
        t_mode              mode;
        logic [23:0]        sample;
        bit                 known;
        logic signed [21:0] want;
    } t_vector;

    t_vector vectors[] = '{
        '{MODE_ISQRT, 24'd0,        1'b1, 22'sd0},
        '{MODE_ISQRT, 24'h7FFFFF,   1'b0, 22'sd0},
        '{MODE_ISQRT, 24'h800000,   1'b0, 22'sd0},
        '{MODE_ISQRT, 24'd1048576,  1'b0, 22'sd0},
        '{MODE_ISQRT, 24'hFFFFFF,   1'b0, 22'sd0},
        '{MODE_CUBIC, 24'd0,        1'b1, 22'sd0},
        '{MODE_CUBIC, 24'd1572864,  1'b1, 22'sd1048576},
        '{MODE_CUBIC, 24'h7FFFFF,   1'b1, 22'sd1048576},
        '{MODE_CUBIC, 24'h800000,   1'b1, -22'sd1048576},
        '{MODE_CUBIC, 24'd1048576,  1'b0, 22'sd0},
        '{MODE_CUBIC, 24'd1,        1'b0, 22'sd0},
        '{MODE_HARD,  24'h7FFFFF,   1'b1, 22'sd1048576},
        '{MODE_HARD,  24'h800000,   1'b1, -22'sd1048576},
        '{MODE_HARD,  24'd1048575,  1'b1, 22'sd1048575},
        '{MODE_HARD,  -24'd1048577, 1'b1, -22'sd1048576},
        '{MODE_HARD,  24'hFFFFFF,   1'b1, -22'sd1},
        '{MODE_NONE,  24'h7FFFFF,   1'b1, 22'sd0},
        '{MODE_NONE,  24'h800000,   1'b1, 22'sd0},
        '{MODE_ISQRT, 24'h555555,   1'b0, 22'sd0},
        '{MODE_ISQRT, 24'hAAAAAA,   1'b0, 22'sd0}
    };

    // Mostly audio-range values, sometimes anything in 24 bits.
    function automatic logic [23:0] rand_sample();
        case ($urandom_range(3))
            0:       return 24'($urandom);
            1:       return 24'($signed($urandom_range(0, 2 * 1572864)) - 1572864);
            2:       return 24'($signed($urandom_range(0, 2 * 1048576)) - 1048576);
            default: return 24'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    initial begin
        t_mode modes[4] = '{MODE_ISQRT, MODE_CUBIC, MODE_HARD, MODE_NONE};
        int    idle_set[4] = '{0, 69, 0, 27};
        int    stall_set[4] = '{0, 0, 69, 27};
        cur_mode = MODE_ISQRT;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, reset mode first
        foreach (vectors[i]) begin
            if (vectors[i].mode != cur_mode || i == 0) begin
                drain();
                write_mode(vectors[i].mode);
            end
            if (vectors[i].known) send_sample(vectors[i].sample, vectors[i].want);
            else send_checked(vectors[i].sample);
        end
        drain();

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_recv = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_recv = 1'b0;
            end
            repeat (60) send_checked(rand_sample());
        join
        drain();

        // random phases over every idling and stall pattern, each in a randomly chosen mode
        for (int ph = 0; ph < 16; ph++) begin
            send_idle_pct  = idle_set[ph % 4];
            recv_stall_pct = stall_set[(ph / 4) % 4];
            write_mode(modes[$urandom_range(3)]);
            repeat (28) send_checked(rand_sample());
            drain();
        end

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
